// ----- rtl/i2cmras_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmras_pkg
// Shared types and constants of the I2C master register access sequencer:
// word layouts, opcodes, bus status codes and command codes.
// ----------------------------------------------------------------------------
package i2cmras_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_LEN);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_BEGIN_WR = 2'd1,
    OP_BEGIN_RD = 2'd2,
    OP_STATUS   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  // bus controller status codes
  localparam logic [7:0] SC_START       = 8'h08;
  localparam logic [7:0] SC_RSTART      = 8'h10;
  localparam logic [7:0] SC_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] SC_ADDR_W_NACK = 8'h20;
  localparam logic [7:0] SC_DATA_TX_ACK = 8'h28;
  localparam logic [7:0] SC_DATA_TX_NAK = 8'h30;
  localparam logic [7:0] SC_ARB_LOST    = 8'h38;
  localparam logic [7:0] SC_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] SC_ADDR_R_NACK = 8'h48;
  localparam logic [7:0] SC_DATA_RX_ACK = 8'h50;
  localparam logic [7:0] SC_DATA_RX_NAK = 8'h58;

  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  localparam logic [1:0] START_NONE     = 2'd0;
  localparam logic [1:0] START_REQ      = 2'd1;
  localparam logic [1:0] START_WITHDRAW = 2'd2;

  localparam logic [1:0] ACK_NONE    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  localparam logic [1:0] OUTC_BUSY = 2'd0;
  localparam logic [1:0] OUTC_OK   = 2'd1;
  localparam logic [1:0] OUTC_NACK = 2'd2;

  typedef struct packed {
    op_e        opcode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [6:0] length;
    logic [5:0] tx_index;
    logic [7:0] tx_byte;
    logic [7:0] status_code;
    logic [7:0] bus_rx_byte;
  } req_t;

  typedef struct packed {
    logic [1:0] start_cmd;
    logic       stop_cmd;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [1:0] ack_cmd;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [5:0] rx_position;
    logic [1:0] outcome;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

endpackage

// ----- rtl/i2cmras_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmras_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface i2cmras_req_if import i2cmras_pkg::*; ();

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/i2cmras_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmras_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface i2cmras_rsp_if import i2cmras_pkg::*; ();

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/i2cmras_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmras_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module i2cmras_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/i2cmras_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmras_seq
// Transfer sequencer: holds the transfer context and decides the result of
// one request word from its opcode, the bus status code and the byte count.
// ----------------------------------------------------------------------------
module i2cmras_seq import i2cmras_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  req_t             req_i,
  input  logic [7:0]       buf_word_i,
  output rsp_t             rsp_o,
  output buf_wr_t          buf_wr_o,
  output logic [IDX_W-1:0] buf_raddr_o
);

  phase_e           phase_q, phase_d;
  logic [6:0]       addr_q, addr_d;
  logic [7:0]       reg_q, reg_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] len_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      addr_q  <= '0;
      reg_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      reg_q   <= reg_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cnt_inc     = cnt_q + LEN_W'(1);
  assign buf_raddr_o = cnt_d[IDX_W-1:0];

  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    reg_d    = reg_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    rsp_o    = '0;
    buf_wr_o = '0;
    len_in   = LEN_W'(req_i.length);
    if (fire_i) begin
      unique case (req_i.opcode)
        OP_LOAD: begin
          buf_wr_o.en   = 1'b1;
          buf_wr_o.addr = req_i.tx_index;
          buf_wr_o.data = req_i.tx_byte;
        end
        OP_BEGIN_WR, OP_BEGIN_RD: begin
          if (len_in < LEN_MIN) begin
            len_d = LEN_MIN;
          end else if (len_in > LEN_MAX) begin
            len_d = LEN_MAX;
          end else begin
            len_d = len_in;
          end
          addr_d          = req_i.dev_addr;
          reg_d           = req_i.reg_addr;
          cnt_d           = '0;
          phase_d         = (req_i.opcode == OP_BEGIN_WR) ? PH_WRITE : PH_READ;
          rsp_o.start_cmd = START_REQ;
        end
        OP_STATUS: begin
          unique case (phase_q)
            PH_WRITE: begin
              unique case (req_i.status_code) inside
                SC_START, SC_RSTART: begin
                  rsp_o.start_cmd  = START_WITHDRAW;
                  rsp_o.send_valid = 1'b1;
                  rsp_o.send_byte  = {addr_q, RW_WRITE};
                end
                SC_ADDR_W_ACK: begin
                  rsp_o.send_valid = 1'b1;
                  rsp_o.send_byte  = reg_q;
                end
                SC_DATA_TX_ACK: begin
                  if (cnt_q < len_q && cnt_q < LEN_MAX) begin
                    rsp_o.send_valid = 1'b1;
                    rsp_o.send_byte  = buf_word_i;
                    cnt_d            = cnt_inc;
                  end else begin
                    rsp_o.stop_cmd = 1'b1;
                    rsp_o.outcome  = OUTC_OK;
                    phase_d        = PH_IDLE;
                  end
                end
                SC_ADDR_W_NACK, SC_DATA_TX_NAK: begin
                  rsp_o.stop_cmd = 1'b1;
                  rsp_o.outcome  = OUTC_NACK;
                  phase_d        = PH_IDLE;
                end
                SC_ARB_LOST: begin
                  rsp_o.start_cmd = START_REQ;
                  cnt_d           = '0;
                end
                default: begin
                end
              endcase
            end
            PH_READ: begin
              unique case (req_i.status_code) inside
                SC_START: begin
                  rsp_o.start_cmd  = START_WITHDRAW;
                  rsp_o.send_valid = 1'b1;
                  rsp_o.send_byte  = {addr_q, RW_WRITE};
                end
                SC_ADDR_W_ACK: begin
                  rsp_o.send_valid = 1'b1;
                  rsp_o.send_byte  = reg_q;
                end
                SC_DATA_TX_ACK: begin
                  rsp_o.start_cmd = START_REQ;
                end
                SC_RSTART: begin
                  rsp_o.start_cmd  = START_WITHDRAW;
                  rsp_o.send_valid = 1'b1;
                  rsp_o.send_byte  = {addr_q, RW_READ};
                end
                SC_ADDR_R_ACK: begin
                  rsp_o.ack_cmd = (len_q > LEN_MIN) ? ACK_ENABLE : ACK_DISABLE;
                end
                SC_DATA_RX_ACK: begin
                  rsp_o.rx_valid    = 1'b1;
                  rsp_o.rx_data     = req_i.bus_rx_byte;
                  rsp_o.rx_position = cnt_q[5:0];
                  cnt_d             = cnt_inc;
                  if (cnt_inc >= len_q) begin
                    rsp_o.stop_cmd = 1'b1;
                    rsp_o.outcome  = OUTC_OK;
                    phase_d        = PH_IDLE;
                  end else if ({1'b0, cnt_inc} + 8'd1 == {1'b0, len_q}) begin
                    rsp_o.ack_cmd = ACK_DISABLE;
                  end
                end
                SC_DATA_RX_NAK: begin
                  rsp_o.rx_valid    = 1'b1;
                  rsp_o.rx_data     = req_i.bus_rx_byte;
                  rsp_o.rx_position = cnt_q[5:0];
                  cnt_d             = cnt_inc;
                  rsp_o.stop_cmd    = 1'b1;
                  rsp_o.outcome     = OUTC_OK;
                  phase_d           = PH_IDLE;
                end
                SC_ADDR_W_NACK, SC_DATA_TX_NAK, SC_ADDR_R_NACK: begin
                  rsp_o.stop_cmd = 1'b1;
                  rsp_o.outcome  = OUTC_NACK;
                  phase_d        = PH_IDLE;
                end
                default: begin
                  rsp_o.start_cmd = START_REQ;
                  cnt_d           = '0;
                end
              endcase
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/i2c_master_register_access_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_sequencer_core
// Drives a byte-level I2C bus controller through register writes and reads.
// ----------------------------------------------------------------------------
// One request word is taken every clock cycle while the input register can
// pass its word on, and gives exactly one result word: the word sits in an
// input register while the sequencer decides its commands, and the result
// lands in an output register, which offers it. While the output register
// waits on a stalled receiver the input register still takes one more
// request word; after that the input is held off until the result is taken.
// Payload bytes for a write live in a 64-entry buffer RAM;
// its read address follows the next byte count, so the byte a data-ack event
// needs is already read out when that event arrives, and a load to the same
// slot in the cycle before is forwarded. Buffer slots never loaded read as
// unknown data.
module i2c_master_register_access_sequencer_core import i2cmras_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  i2cmras_req_if.sink   req_i,
  i2cmras_rsp_if.source rsp_o
);

  logic             in_valid_q;
  req_t             in_q;
  logic             out_valid_q;
  rsp_t             out_q;
  logic             fire;
  rsp_t             result;
  buf_wr_t          buf_wr;
  logic [IDX_W-1:0] buf_raddr;
  logic [7:0]       ram_rdata;
  logic             fwd_q;
  logic [7:0]       fwd_data_q;
  logic [7:0]       buf_word;

  assign fire        = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || fire;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      fwd_q <= buf_wr.en && (buf_wr.addr == buf_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.data;
    end
    if (fire) begin
      out_q <= result;
    end
    fwd_data_q <= buf_wr.data;
  end

  assign buf_word = fwd_q ? fwd_data_q : ram_rdata;

  i2cmras_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_wr.en),
    .waddr_i (buf_wr.addr),
    .wdata_i (buf_wr.data),
    .raddr_i (buf_raddr),
    .rdata_o (ram_rdata)
  );

  i2cmras_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (in_q),
    .buf_word_i  (buf_word),
    .rsp_o       (result),
    .buf_wr_o    (buf_wr),
    .buf_raddr_o (buf_raddr)
  );

endmodule

// ----- tb/sv/tb_i2c_master_register_access_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_register_access_sequencer_core
// Self-checking bench for the I2C register access sequencer. A queue of
// request words drives register write and read transfers with random content,
// disturbed by arbitration loss, NACKs, stray codes and abandoned transfers.
// Each accepted word is run through an in-bench model of the sequencer and
// the forecast bus commands are compared field by field with the result words.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_sequencer_core;
  import i2cmras_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1250;

  logic clk_i;
  logic rst_ni;

  i2cmras_req_if req_if ();
  i2cmras_rsp_if rsp_if ();

  i2c_master_register_access_sequencer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_t pending_words [$];
  rsp_t expected_cmds [$];

  // model of the sequencer
  phase_e      m_phase;
  logic [6:0]  m_addr;
  logic [7:0]  m_reg;
  int unsigned m_len;
  int unsigned m_count;
  logic [7:0]  pay_buf [MAX_LEN];

  int unsigned total_words;
  int unsigned words_in;
  int unsigned results_in;
  int unsigned errors;
  int unsigned writes_ok;
  int unsigned reads_ok;
  int unsigned nack_ends;
  int unsigned bytes_rx;

  int unsigned req_gap;
  int unsigned rsp_stall;
  int unsigned hold_left;
  int unsigned holds_done;
  bit          req_lazy;
  bit          rsp_lazy;
  logic        squeeze;

  function automatic rsp_t predict_bus_cmds(req_t w);
    rsp_t        r;
    int unsigned len;
    r = '0;
    case (w.opcode)
      OP_LOAD: pay_buf[w.tx_index] = w.tx_byte;
      OP_BEGIN_WR, OP_BEGIN_RD: begin
        len = w.length;
        if (len < 1) len = 1;
        if (len > MAX_LEN) len = MAX_LEN;
        m_addr = w.dev_addr;
        m_reg = w.reg_addr;
        m_len = len;
        m_count = 0;
        m_phase = (w.opcode == OP_BEGIN_WR) ? PH_WRITE : PH_READ;
        r.start_cmd = START_REQ;
      end
      default: begin
        if (m_phase == PH_WRITE) begin
          case (w.status_code)
            SC_START, SC_RSTART: begin
              r.start_cmd = START_WITHDRAW;
              r.send_valid = 1'b1;
              r.send_byte = {m_addr, RW_WRITE};
            end
            SC_ADDR_W_ACK: begin
              r.send_valid = 1'b1;
              r.send_byte = m_reg;
            end
            SC_DATA_TX_ACK: begin
              if (m_count < m_len) begin
                r.send_valid = 1'b1;
                r.send_byte = pay_buf[m_count];
                m_count++;
              end else begin
                r.stop_cmd = 1'b1;
                r.outcome = OUTC_OK;
                m_phase = PH_IDLE;
              end
            end
            SC_ADDR_W_NACK, SC_DATA_TX_NAK: begin
              r.stop_cmd = 1'b1;
              r.outcome = OUTC_NACK;
              m_phase = PH_IDLE;
            end
            SC_ARB_LOST: begin
              r.start_cmd = START_REQ;
              m_count = 0;
            end
            default: ;
          endcase
        end else if (m_phase == PH_READ) begin
          case (w.status_code)
            SC_START: begin
              r.start_cmd = START_WITHDRAW;
              r.send_valid = 1'b1;
              r.send_byte = {m_addr, RW_WRITE};
            end
            SC_ADDR_W_ACK: begin
              r.send_valid = 1'b1;
              r.send_byte = m_reg;
            end
            SC_DATA_TX_ACK: r.start_cmd = START_REQ;
            SC_RSTART: begin
              r.start_cmd = START_WITHDRAW;
              r.send_valid = 1'b1;
              r.send_byte = {m_addr, RW_READ};
            end
            SC_ADDR_R_ACK: r.ack_cmd = (m_len > 1) ? ACK_ENABLE : ACK_DISABLE;
            SC_DATA_RX_ACK, SC_DATA_RX_NAK: begin
              r.rx_valid = 1'b1;
              r.rx_data = w.bus_rx_byte;
              r.rx_position = 6'(m_count);
              m_count++;
              if (w.status_code == SC_DATA_RX_NAK || m_count >= m_len) begin
                r.stop_cmd = 1'b1;
                r.outcome = OUTC_OK;
                m_phase = PH_IDLE;
              end else if (m_count + 1 == m_len) begin
                r.ack_cmd = ACK_DISABLE;
              end
            end
            SC_ADDR_W_NACK, SC_DATA_TX_NAK, SC_ADDR_R_NACK: begin
              r.stop_cmd = 1'b1;
              r.outcome = OUTC_NACK;
              m_phase = PH_IDLE;
            end
            default: begin
              r.start_cmd = START_REQ;
              m_count = 0;
            end
          endcase
        end
      end
    endcase
    return r;
  endfunction

  function automatic req_t noise_word();
    req_t w;
    w.opcode = op_e'($urandom_range(0, 3));
    w.dev_addr = 7'($urandom);
    w.reg_addr = 8'($urandom);
    w.length = 7'($urandom);
    w.tx_index = 6'($urandom);
    w.tx_byte = 8'($urandom);
    w.status_code = 8'($urandom);
    w.bus_rx_byte = 8'($urandom);
    return w;
  endfunction

  task automatic push_load(int unsigned idx, logic [7:0] value);
    req_t w;
    w = noise_word();
    w.opcode = OP_LOAD;
    w.tx_index = 6'(idx);
    w.tx_byte = value;
    pending_words.push_back(w);
  endtask

  task automatic push_begin(op_e op, logic [6:0] dev, logic [7:0] rega, logic [6:0] len);
    req_t w;
    w = noise_word();
    w.opcode = op;
    w.dev_addr = dev;
    w.reg_addr = rega;
    w.length = len;
    pending_words.push_back(w);
  endtask

  task automatic push_status(logic [7:0] code, int rx = -1);
    req_t w;
    w = noise_word();
    w.opcode = OP_STATUS;
    w.status_code = code;
    if (rx >= 0) w.bus_rx_byte = 8'(rx);
    pending_words.push_back(w);
  endtask

  function automatic logic [6:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'(MAX_LEN);
    if (r == 2) return 7'($urandom_range(MAX_LEN + 1, 127));
    if (r < 5) return 7'($urandom_range(9, MAX_LEN - 1));
    return 7'($urandom_range(1, 8));
  endfunction

  // one transfer with random content, sometimes disturbed
  task automatic push_transfer(bit rd);
    logic [7:0]  codes [$];
    logic [7:0]  mixed [$];
    logic [7:0]  fault;
    logic [6:0]  lraw;
    int unsigned len;
    int unsigned p;
    int unsigned kind;
    lraw = pick_len();
    len = (lraw == 0) ? 1 : (lraw > MAX_LEN) ? MAX_LEN : lraw;
    if (!rd) begin
      repeat ($urandom_range(0, 3)) push_load($urandom_range(0, len - 1), 8'($urandom));
    end
    push_begin(rd ? OP_BEGIN_RD : OP_BEGIN_WR, 7'($urandom), 8'($urandom), lraw);
    if (rd) begin
      codes = '{SC_START, SC_ADDR_W_ACK, SC_DATA_TX_ACK, SC_RSTART, SC_ADDR_R_ACK};
      repeat (len - 1) codes.push_back(SC_DATA_RX_ACK);
      codes.push_back(SC_DATA_RX_NAK);
    end else begin
      codes = '{SC_START, SC_ADDR_W_ACK};
      repeat (len + 1) codes.push_back(SC_DATA_TX_ACK);
    end
    if ($urandom_range(0, 3) == 0) begin
      p = $urandom_range(0, codes.size() - 1);
      kind = $urandom_range(0, 3);
      case (kind)
        0: fault = SC_ARB_LOST;
        1: begin
          case ($urandom_range(0, 2))
            0: fault = SC_ADDR_W_NACK;
            1: fault = SC_DATA_TX_NAK;
            default: fault = SC_ADDR_R_NACK;
          endcase
        end
        default: fault = 8'($urandom);
      endcase
      for (int i = 0; i < codes.size(); i++) begin
        if (i == p) begin
          if (kind == 3) break;
          mixed.push_back(fault);
          // retry from the start condition
          if (kind == 0 || (kind == 2 && rd)) begin
            for (int j = 0; j < p; j++) mixed.push_back(codes[j]);
          end
        end
        mixed.push_back(codes[i]);
      end
      codes = mixed;
    end
    foreach (codes[i]) begin
      if ($urandom_range(0, 15) == 0) push_load($urandom_range(0, MAX_LEN - 1), 8'($urandom));
      push_status(codes[i]);
    end
  endtask

  function automatic int unsigned draw_wait(bit lazy);
    return lazy ? $urandom_range(0, 15) : 0;
  endfunction

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    results_in++;
    if (expected_cmds.size() == 0) begin
      errors++;
      $display("%0t ns: result word with none expected, expected none actual %h", $time, got);
      return;
    end
    want = expected_cmds.pop_front();
    cmp_field("start_cmd", want.start_cmd, got.start_cmd);
    cmp_field("stop_cmd", want.stop_cmd, got.stop_cmd);
    cmp_field("send_valid", want.send_valid, got.send_valid);
    cmp_field("send_byte", want.send_byte, got.send_byte);
    cmp_field("ack_cmd", want.ack_cmd, got.ack_cmd);
    cmp_field("rx_valid", want.rx_valid, got.rx_valid);
    cmp_field("rx_data", want.rx_data, got.rx_data);
    cmp_field("rx_position", want.rx_position, got.rx_position);
    cmp_field("outcome", want.outcome, got.outcome);
    if (want.rx_valid) bytes_rx++;
    if (want.outcome == OUTC_NACK) nack_ends++;
    if (want.outcome == OUTC_OK) begin
      if (want.rx_valid) reads_ok++;
      else writes_ok++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_cmds.push_back(predict_bus_cmds(req_if.data));
        words_in++;
        if (words_in % 40 == 0) req_lazy = ($urandom_range(0, 2) != 0);
        req_gap = draw_wait(req_lazy);
      end
      if (squeeze) req_gap = 0;
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.data <= pending_words.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off so the sequencer backs up into its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      squeeze <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && results_in >= (holds_done == 0 ? 300 : 900)) begin
        hold_left <= 240;
        holds_done <= holds_done + 1;
      end
      squeeze <= (hold_left != 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        check_result(rsp_if.data);
        if (results_in % 37 == 0) rsp_lazy = ($urandom_range(0, 2) != 0);
        rsp_stall = draw_wait(rsp_lazy);
      end else if (rsp_stall != 0) begin
        rsp_stall--;
      end
      rsp_if.ready <= (rsp_stall == 0 && hold_left == 0);
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned base;
    m_phase = PH_IDLE;
    m_addr = '0;
    m_reg = '0;
    m_len = 0;
    m_count = 0;
    words_in = 0;
    results_in = 0;
    errors = 0;
    writes_ok = 0;
    reads_ok = 0;
    nack_ends = 0;
    bytes_rx = 0;
    req_gap = 0;
    rsp_stall = 0;
    hold_left = 0;
    holds_done = 0;
    req_lazy = 1'b0;
    rsp_lazy = 1'b0;

    // fill the whole payload buffer first
    for (int i = 0; i < MAX_LEN; i++) push_load(i, 8'($urandom));

    // directed transfers
    push_status(SC_START);
    push_begin(OP_BEGIN_WR, 7'h7f, 8'hff, 7'd0);
    push_status(SC_RSTART);
    push_status(SC_ADDR_W_ACK);
    push_status(SC_DATA_TX_ACK);
    push_status(SC_DATA_TX_ACK);
    push_begin(OP_BEGIN_WR, 7'h00, 8'h00, 7'd127);
    push_status(SC_ARB_LOST);
    push_status(SC_START);
    push_status(SC_ADDR_W_NACK);
    push_begin(OP_BEGIN_RD, 7'h55, 8'haa, 7'd1);
    push_status(SC_START);
    push_status(SC_ADDR_W_ACK);
    push_status(SC_DATA_TX_ACK);
    push_status(SC_RSTART);
    push_status(SC_ADDR_R_ACK);
    push_status(SC_DATA_RX_NAK, 8'hff);
    push_begin(OP_BEGIN_RD, 7'h2a, 8'h55, 7'd2);
    push_status(8'he7);
    push_status(SC_ADDR_R_ACK);
    push_status(SC_DATA_RX_ACK, 8'h00);
    push_status(SC_DATA_RX_ACK, 8'ha5);
    push_begin(OP_BEGIN_WR, 7'h11, 8'h3c, 7'd64);
    push_status(8'hc3);
    push_begin(OP_BEGIN_RD, 7'h22, 8'hc3, 7'd5);
    push_status(SC_ADDR_R_NACK);
    push_begin(OP_BEGIN_WR, 7'h33, 8'h0f, 7'd2);
    push_status(SC_DATA_TX_ACK);
    push_status(SC_DATA_TX_NAK);

    // random transfers with some noise in between
    base = pending_words.size();
    while (pending_words.size() < base + RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_transfer(1'b0);
        4, 5, 6, 7: push_transfer(1'b1);
        default: begin
          repeat ($urandom_range(1, 4)) pending_words.push_back(noise_word());
        end
      endcase
    end
    total_words = pending_words.size();

    while (words_in != total_words) @(negedge clk_i);
    while (expected_cmds.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("run covered %0d request words and %0d result words", words_in, results_in);
    $display("writes ok %0d, reads ok %0d, ended on nack %0d, bytes received %0d",
             writes_ok, reads_ok, nack_ends, bytes_rx);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
